### hw/rtl/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared widths, constants and helpers for the barometric compensation core.
// ----------------------------------------------------------------------------
`default_nettype none
package btpc_pkg;
  localparam int AdcW     = 20;
  localparam int WordW    = 32;
  localparam int CfgW     = 64;
  localparam int CfgIdxW  = 2;
  localparam int DivStages = 32;

  localparam logic [CfgIdxW-1:0] RegTemp      = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressHigh = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPressLast = 2'd3;

  localparam logic [31:0] K64000  = 32'd64000;
  localparam logic [31:0] K1M     = 32'd1048576;
  localparam logic [31:0] K3125   = 32'd3125;
  localparam logic [31:0] KMsb    = 32'h8000_0000;
  localparam logic [31:0] K32768  = 32'd32768;
  localparam logic [31:0] K128    = 32'd128;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic word_t mul32(input word_t a, input word_t b);
    logic [63:0] full;
    full = a * b;
    mul32 = full[31:0];
  endfunction

  function automatic word_t asr(input word_t x, input int n);
    asr = word_t'($signed(x) >>> n);
  endfunction
endpackage
`default_nettype wire

### hw/rtl/btpc_divider.sv
// ----------------------------------------------------------------------------
// btpc_divider
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module btpc_divider
  import btpc_pkg::*;
#(
  parameter int W = WordW
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  input  wire logic         dbl_after,
  output logic              out_valid,
  output logic [W-1:0]      quot,
  output logic              out_dbl
);
  logic         vld [W+1];
  logic [W-1:0] rem [W+1];
  logic [W-1:0] qq  [W+1];
  logic [W-1:0] dd  [W+1];
  logic         db  [W+1];

  always_comb begin
    vld[0] = in_valid;
    rem[0] = '0;
    qq[0]  = num;
    dd[0]  = den;
    db[0]  = dbl_after;
  end

  for (genvar s = 0; s < W; s++) begin : g_st
    logic [W:0] trial;
    logic [W:0] diff;
    always_comb begin
      trial = {rem[s], qq[s][W-1]};
      diff  = trial - {1'b0, dd[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      if (!diff[W]) begin
        rem[s+1] <= diff[W-1:0];
        qq[s+1]  <= {qq[s][W-2:0], 1'b1};
      end else begin
        rem[s+1] <= trial[W-1:0];
        qq[s+1]  <= {qq[s][W-2:0], 1'b0};
      end
      dd[s+1] <= dd[s];
      db[s+1] <= db[s];
    end
  end

  assign out_valid = vld[W];
  assign quot      = qq[W];
  assign out_dbl   = db[W];
endmodule
`default_nettype wire

### hw/rtl/baro_temp_press_compensation_core.sv
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_core
// 32-bit integer temperature and pressure compensation pipeline.
// ----------------------------------------------------------------------------
// One item (adc_press, adc_temp) may start every cycle; busy is always low.
// Each result appears with strobe after passing through eleven
// front stages of multiplies and shifts ahead of a 32-stage
// one-bit-per-stage divider, then four stages of correction and output.
// Results cannot be held off, so the receiver must take each strobe.
`default_nettype none
module baro_temp_press_compensation_core
  import btpc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [AdcW-1:0]     adc_press,
  input  wire logic [AdcW-1:0]     adc_temp,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgW-1:0]     cfg_data,
  output logic                     strobe,
  output logic signed [WordW-1:0]  temp_centi,
  output logic [WordW-1:0]         press_pa,
  output logic                     div_zero
);
  logic [47:0] tc;
  logic [63:0] pl, ph;
  logic [15:0] p9r;

  always_ff @(posedge clk) begin
    if (rst) begin
      tc <= '0; pl <= '0; ph <= '0; p9r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegTemp:      tc  <= cfg_data[47:0];
        RegPressLow:  pl  <= cfg_data;
        RegPressHigh: ph  <= cfg_data;
        RegPressLast: p9r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, tc[15:0]};
  assign t2 = sx16(tc[31:16]);
  assign t3 = sx16(tc[47:32]);
  assign p1 = {16'd0, pl[15:0]};
  assign p2 = sx16(pl[31:16]);
  assign p3 = sx16(pl[47:32]);
  assign p4 = sx16(pl[63:48]);
  assign p5 = sx16(ph[15:0]);
  assign p6 = sx16(ph[31:16]);
  assign p7 = sx16(ph[47:32]);
  assign p8 = sx16(ph[63:48]);
  assign p9 = sx16(p9r);

  assign busy = 1'b0;

  // Front stages: s1..s11 then divider.
  logic [8:1] v;
  word_t a1, d1, ap1;
  word_t v1a, dd2, ap2;
  word_t v1b, dsh3, ap3;
  word_t v1c, v2c, ap4;
  word_t tf5, ap5;
  word_t tmp6, pv1_6, q6, ap6;
  word_t tmp7, qq7, v1p5_7, p2v1_7, ap7;
  word_t tmp8, v2_8, p3qq_8, p2v1_8, ap8;
  word_t tmp9, v2_9, pv1_9, ap9;
  word_t tmp10, v2_10, div10, ap10;
  word_t tmp11, div11, num11;
  logic  v9, v10, v11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0; v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0;
    end else begin
      v <= {v[7:1], start};
      v9 <= v[8]; v10 <= v9; v11 <= v10;
    end
    // s1
    a1  <= {15'd0, adc_temp[AdcW-1:3]} - (t1 << 1);
    d1  <= {16'd0, adc_temp[AdcW-1:4]} - t1;
    ap1 <= {12'd0, adc_press};
    // s2
    v1a <= mul32(a1, t2);
    dd2 <= mul32(d1, d1);
    ap2 <= ap1;
    // s3
    v1b  <= asr(v1a, 11);
    dsh3 <= asr(dd2, 12);
    ap3  <= ap2;
    // s4
    v1c <= v1b;
    v2c <= asr(mul32(dsh3, t3), 14);
    ap4 <= ap3;
    // s5
    tf5 <= v1c + v2c;
    ap5 <= ap4;
    // s6
    tmp6  <= asr(mul32(tf5, 32'd5) + K128, 8);
    pv1_6 <= asr(tf5, 1) - K64000;
    q6    <= asr(asr(tf5, 1) - K64000, 2);
    ap6   <= ap5;
    // s7
    tmp7   <= tmp6;
    qq7    <= mul32(q6, q6);
    v1p5_7 <= mul32(pv1_6, p5) << 1;
    p2v1_7 <= mul32(p2, pv1_6);
    ap7    <= ap6;
    // s8
    tmp8   <= tmp7;
    v2_8   <= mul32(asr(qq7, 11), p6) + v1p5_7;
    p3qq_8 <= mul32(p3, asr(qq7, 13));
    p2v1_8 <= p2v1_7;
    ap8    <= ap7;
    // s9
    tmp9  <= tmp8;
    v2_9  <= asr(v2_8, 2) + (p4 << 16);
    pv1_9 <= asr(asr(p3qq_8, 3) + asr(p2v1_8, 1), 18);
    ap9   <= ap8;
    // s10
    tmp10 <= tmp9;
    v2_10 <= v2_9;
    div10 <= asr(mul32(K32768 + pv1_9, p1), 15);
    ap10  <= ap9;
    // s11
    tmp11 <= tmp10;
    div11 <= div10;
    num11 <= mul32((K1M - ap10) - asr(v2_10, 12), K3125);
  end

  // Divider, with the operands that ride alongside.
  logic  big;
  word_t dnum;
  logic  dv;
  word_t dq;
  logic  ddbl;
  assign big  = (num11 >= KMsb);
  assign dnum = big ? num11 : (num11 << 1);

  logic        dz_in;
  assign dz_in = (div11 == '0);

  word_t tmp_sh [DivStages+1];
  logic  dz_sh  [DivStages+1];
  always_comb begin
    tmp_sh[0] = tmp11;
    dz_sh[0]  = dz_in;
  end
  for (genvar k = 0; k < DivStages; k++) begin : g_side
    always_ff @(posedge clk) begin
      tmp_sh[k+1] <= tmp_sh[k];
      dz_sh[k+1]  <= dz_sh[k];
    end
  end

  btpc_divider #(.W(WordW)) u_div (
    .clk(clk), .rst(rst), .in_valid(v11), .num(dnum),
    .den(dz_in ? 32'd1 : div11), .dbl_after(big),
    .out_valid(dv), .quot(dq), .out_dbl(ddbl)
  );

  // Back stages.
  logic  b1v, b2v, b3v;
  word_t b1p, b1t, b2p, b2t, b2v1, b2v2, b3p, b3t, b3sum;
  logic  b1z, b2z, b3z;
  always_ff @(posedge clk) begin
    if (rst) begin
      b1v <= 1'b0; b2v <= 1'b0; b3v <= 1'b0; strobe <= 1'b0;
    end else begin
      b1v <= dv; b2v <= b1v; b3v <= b2v; strobe <= b3v;
    end
    b1p <= ddbl ? (dq << 1) : dq;
    b1t <= tmp_sh[DivStages];
    b1z <= dz_sh[DivStages];
    // square of p/8, then scale
    b2p  <= b1p;
    b2t  <= b1t;
    b2z  <= b1z;
    b2v1 <= mul32(b1p >> 3, b1p >> 3) >> 13;
    b2v2 <= asr(mul32(b1p >> 2, p8), 13);
    b3p  <= b2p;
    b3t  <= b2t;
    b3z  <= b2z;
    b3sum <= asr(mul32(p9, b2v1), 12) + b2v2 + p7;
    temp_centi <= b3t;
    press_pa   <= b3z ? '0 : (b3p + asr(b3sum, 4));
    div_zero   <= b3z;
  end

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (rst) b3v |=> strobe)
    else $error("strobe lost");
  a_dz: assert property (@(posedge clk) disable iff (rst)
    (strobe && div_zero) |-> (press_pa == '0))
    else $error("pressure not zero on zero divisor");
endmodule
`default_nettype wire

### dv/baro_temp_press_compensation_core_tb.sv
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_core_tb
// Drives raw pressure/temperature items through the compensation core under
// several calibration sets and checks every result against a local model.
// ----------------------------------------------------------------------------
`default_nettype none
module baro_temp_press_compensation_core_tb;
  import btpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [AdcW-1:0] press;
    logic [AdcW-1:0] temp;
  } raw_item_t;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] press_pa;
    logic        div_zero;
  } comp_item_t;

  localparam int Latency = 46;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [AdcW-1:0] adc_press = '0;
  logic [AdcW-1:0] adc_temp = '0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  wire logic busy;
  wire logic strobe;
  wire logic signed [WordW-1:0] temp_centi;
  wire logic [WordW-1:0] press_pa;
  wire logic div_zero;

  baro_temp_press_compensation_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .adc_press(adc_press), .adc_temp(adc_temp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .temp_centi(temp_centi), .press_pa(press_pa),
    .div_zero(div_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // calibration copy
  logic [47:0] cal_temp = '0;
  logic [63:0] cal_plo = '0;
  logic [63:0] cal_phi = '0;
  logic [15:0] cal_p9 = '0;

  raw_item_t pending_items[$];
  comp_item_t expected_results[$];
  int errors = 0;
  bit feeding = 1'b0;
  int gap = 0;

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic comp_item_t compensate(input raw_item_t it);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, d, v1, v2, q, tf, p, dv;
    comp_item_t r;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = ext16(cal_temp[31:16]);
    t3 = ext16(cal_temp[47:32]);
    p1 = {16'd0, cal_plo[15:0]};
    p2 = ext16(cal_plo[31:16]);
    p3 = ext16(cal_plo[47:32]);
    p4 = ext16(cal_plo[63:48]);
    p5 = ext16(cal_phi[15:0]);
    p6 = ext16(cal_phi[31:16]);
    p7 = ext16(cal_phi[47:32]);
    p8 = ext16(cal_phi[63:48]);
    p9 = ext16(cal_p9);
    a = ({12'd0, it.temp} >> 3) - (t1 << 1);
    v1 = sra(a * t2, 11);
    d = ({12'd0, it.temp} >> 4) - t1;
    v2 = sra(sra(d * d, 12) * t3, 14);
    tf = v1 + v2;
    r.temp_centi = sra(tf * 32'd5 + 32'd128, 8);
    v1 = sra(tf, 1) - 32'd64000;
    q = sra(v1, 2);
    v2 = sra(q * q, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra(v2, 2) + (p4 << 16);
    v1 = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * v1, 1), 18);
    dv = sra((32'd32768 + v1) * p1, 15);
    if (dv == 0) begin
      p = 0;
      r.div_zero = 1'b1;
    end else begin
      r.div_zero = 1'b0;
      p = ((32'd1048576 - {12'd0, it.press}) - sra(v2, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / dv;
      else p = (p / dv) * 32'd2;
      v1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      v2 = sra((p >> 2) * p8, 13);
      p = p + sra(v1 + v2 + p7, 4);
    end
    r.press_pa = p;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    int wait_draw;
    if (rst) begin
      start <= 1'b0;
      gap <= 0;
    end else if (start && !busy) begin
      expected_results.push_back(compensate({adc_press, adc_temp}));
      wait_draw = $urandom_range(0, 6);
      if (feeding && pending_items.size() > 0 && wait_draw == 0) begin
        adc_press <= pending_items[0].press;
        adc_temp <= pending_items[0].temp;
        void'(pending_items.pop_front());
      end else begin
        start <= 1'b0;
        gap <= (wait_draw > 0) ? wait_draw - 1 : 0;
      end
    end else if (!start) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (feeding && pending_items.size() > 0) begin
        start <= 1'b1;
        adc_press <= pending_items[0].press;
        adc_temp <= pending_items[0].temp;
        void'(pending_items.pop_front());
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    comp_item_t got, want;
    if (!rst && strobe) begin
      got = {temp_centi, press_pa, div_zero};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.temp_centi !== want.temp_centi) begin
          $display("%0t: temp_centi expected %h actual %h", $time,
                   want.temp_centi, got.temp_centi);
          errors++;
        end
        if (got.press_pa !== want.press_pa) begin
          $display("%0t: press_pa expected %h actual %h", $time,
                   want.press_pa, got.press_pa);
          errors++;
        end
        if (got.div_zero !== want.div_zero) begin
          $display("%0t: div_zero expected %b actual %b", $time,
                   want.div_zero, got.div_zero);
          errors++;
        end
      end
    end
  end

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      RegTemp:      cal_temp = val[47:0];
      RegPressLow:  cal_plo = val;
      RegPressHigh: cal_phi = val;
      default:      cal_p9 = val[15:0];
    endcase
  endtask

  // wait out all in-flight items, then idle
  task automatic drain();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic load_cal(input logic [47:0] tc, input logic [63:0] lo,
                          input logic [63:0] hi, input logic [15:0] p9);
    write_reg(RegTemp, {16'd0, tc});
    write_reg(RegPressLow, lo);
    write_reg(RegPressHigh, hi);
    write_reg(RegPressLast, {48'd0, p9});
    cfg_we <= 1'b0;
  endtask

  function automatic raw_item_t rand_item();
    raw_item_t it;
    it.press = AdcW'($urandom_range(0, 20'hFFFFF));
    it.temp = AdcW'($urandom_range(0, 20'hFFFFF));
    if ($urandom_range(0, 3) != 0) begin
      // realistic readings near mid-scale
      it.press = AdcW'($urandom_range(20'h40000, 20'hC0000));
      it.temp = AdcW'($urandom_range(20'h60000, 20'hA0000));
    end
    return it;
  endfunction

  // typical datasheet-style calibration
  localparam logic [47:0] TcTyp = {16'hFC18, 16'h6800, 16'h6E80};
  localparam logic [63:0] PloTyp = {16'h0B0C, 16'hD0D0, 16'hD6D4, 16'h8E5C};
  localparam logic [63:0] PhiTyp = {16'hE8A0, 16'h3A98, 16'hFFF9, 16'h0096};
  localparam logic [15:0] P9Typ = 16'h1770;

  initial begin
    logic [AdcW-1:0] edges[4];
    edges = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset calibration gives a zero divisor everywhere
    pending_items.push_back('{20'h00000, 20'h00000});
    pending_items.push_back('{20'hFFFFF, 20'hFFFFF});
    feeding = 1'b1;
    drain();

    load_cal(TcTyp, PloTyp, PhiTyp, P9Typ);
    foreach (edges[i]) foreach (edges[j]) pending_items.push_back('{edges[i], edges[j]});
    pending_items.push_back('{20'h5A3C0, 20'h7E8F0});
    drain();

    // extreme calibration words
    load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    foreach (edges[i]) pending_items.push_back('{edges[i], edges[3 - i]});
    drain();
    load_cal({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h7FFF, 16'h8000, 16'h0001},
             {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
    foreach (edges[i]) pending_items.push_back('{edges[i], edges[i]});
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0 || phase == 3) begin
        load_cal(TcTyp, PloTyp, PhiTyp, P9Typ);
      end else begin
        load_cal(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
                 {$urandom(), $urandom()}, 16'($urandom()));
      end
      for (int k = 0; k < 200; k++) pending_items.push_back(rand_item());
      // hold off the sender until everything is back
      if (phase == 2) begin
        while (pending_items.size() > 100) @(posedge clk);
        feeding = 1'b0;
        while (start || expected_results.size() > 0) @(posedge clk);
        feeding = 1'b1;
      end
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

### baro_temp_press_compensation_core.f
hw/rtl/btpc_pkg.sv
hw/rtl/btpc_divider.sv
hw/rtl/baro_temp_press_compensation_core.sv
dv/baro_temp_press_compensation_core_tb.sv
